>>> design/sphere_texture_shader_unit_defines.svh
// Assertion helpers for the sphere texture shader
`ifndef SPHERE_TEXTURE_SHADER_UNIT_DEFINES_SVH
`define SPHERE_TEXTURE_SHADER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset
`define STS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check that a condition on one edge implies a property on the next edge
`define STS_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> design/sts_pkg.sv
package sts_pkg;

    // Texture geometry
    localparam int TEX_WIDTH  = 128;
    localparam int TEX_HEIGHT = 64;
    localparam int TEX_SIZE   = TEX_WIDTH * TEX_HEIGHT;
    localparam int COL_W      = $clog2(TEX_WIDTH);
    localparam int ROW_W      = $clog2(TEX_HEIGHT);
    localparam int ADDR_W     = $clog2(TEX_SIZE);

    // Field widths
    localparam int IDX_W      = 13;
    localparam int CH_W       = 8;
    localparam int TEXEL_W    = 3 * CH_W;
    localparam int OFS_W      = 9;
    localparam int P_W        = OFS_W + 4;
    localparam int RAD_W      = 12;
    localparam int LON_W      = 16;
    localparam int AMB_W      = 9;
    localparam int IN_TDATA_W = 56;
    localparam int OUT_TDATA_W = TEXEL_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LON_OFS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMBIENT = 2'd2;
    localparam logic [RAD_W-1:0] RADIUS_RST  = 12'd1024;
    localparam logic [AMB_W-1:0] AMBIENT_RST = 9'd128;
    localparam logic [AMB_W-1:0] AMB_FULL    = 9'd256;

    // Commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SHADE = 1'b1;

    // Square root, CORDIC and divider sizing
    localparam int SQ_W         = 25;
    localparam int SQ_STEPS     = 12;
    localparam int CORDIC_STEPS = 20;
    localparam int CW           = 32;
    localparam int ZW           = 25;
    localparam int DIV_STEPS    = 16;
    localparam int DVD_W        = 28;
    localparam int NRM_W        = DIV_STEPS + 1;
    localparam int SUM_W        = NRM_W + 2;
    localparam int DOT_W        = 16;
    localparam int LIGHT_W      = 24;
    localparam int ANG_SHIFT    = 8;
    localparam int LIGHT_SHIFT  = 23;

    localparam logic [14:0] LIGHT_Q15       = 15'd18907;
    localparam logic [DOT_W-1:0] DOT_MAX    = 16'd32768;
    localparam logic [15:0] V_MAX_Q16       = 16'd65470;
    localparam logic signed [ZW-1:0] QUARTER_Q24 = 25'sd4194304;
    localparam logic signed [ZW-1:0] ROUND_Q24   = 25'sd128;
    localparam logic [LON_W-1:0] HALF_TURN_Q16   = 16'h8000;

    // Pipeline stage positions
    localparam int ST_SQ0  = 2;
    localparam int ST_CORD = ST_SQ0 + SQ_STEPS + 1;
    localparam int ST_SUM  = ST_CORD + DIV_STEPS;
    localparam int ST_UV   = ST_CORD + CORDIC_STEPS;
    localparam int ST_ADDR = ST_UV + 1;
    localparam int ST_TEX  = ST_ADDR + 1;
    localparam int ST_OUT  = ST_TEX + 1;
    localparam int N_ST    = ST_OUT + 1;

    typedef struct packed {
        logic                 cmd;
        logic [IDX_W-1:0]     widx;
        logic [TEXEL_W-1:0]   wdata;
        logic                 cov;
    } t_side;

    typedef struct packed {
        logic [SQ_W-1:0]       na;
        logic [SQ_W-1:0]       ra;
        logic [SQ_W-1:0]       nb;
        logic [SQ_W-1:0]       rb;
        logic signed [P_W-1:0] px;
        logic signed [P_W-1:0] py;
    } t_sq;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
        logic                 quarter;
    } t_cord;

    typedef struct packed {
        logic [DVD_W-1:0]     rem;
        logic [DIV_STEPS-1:0] q;
        logic                 neg;
    } t_div;

    typedef struct packed {
        t_div x;
        t_div y;
        t_div z;
    } t_div3;

    // Arctangent of 2^-i in Q0.24 turns
    function automatic logic signed [ZW-1:0] atan_q24(input int i);
        case (i)
            0:  return 25'sd2097152;
            1:  return 25'sd1238021;
            2:  return 25'sd654136;
            3:  return 25'sd332050;
            4:  return 25'sd166669;
            5:  return 25'sd83416;
            6:  return 25'sd41718;
            7:  return 25'sd20860;
            8:  return 25'sd10430;
            9:  return 25'sd5215;
            10: return 25'sd2608;
            11: return 25'sd1304;
            12: return 25'sd652;
            13: return 25'sd326;
            14: return 25'sd163;
            15: return 25'sd81;
            16: return 25'sd41;
            17: return 25'sd20;
            18: return 25'sd10;
            19: return 25'sd5;
            default: return '0;
        endcase
    endfunction

    // Right shift that truncates toward zero
    function automatic logic signed [CW-1:0] shr_trunc(input logic signed [CW-1:0] v,
                                                      input int s);
        if (v >= 0) begin
            return v >>> s;
        end
        return -((-v) >>> s);
    endfunction

    // One vectoring CORDIC rotation
    function automatic t_cord cord_step(input t_cord a, input int i);
        t_cord b;
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        b  = a;
        xs = shr_trunc(a.x, i);
        ys = shr_trunc(a.y, i);
        if (a.y >= 0) begin
            b.x = a.x + ys;
            b.y = a.y - xs;
            b.z = a.z + atan_q24(i);
        end else begin
            b.x = a.x - ys;
            b.y = a.y + xs;
            b.z = a.z - atan_q24(i);
        end
        return b;
    endfunction

    // One restoring division step for quotient bit k
    function automatic t_div div_step(input t_div a, input logic [RAD_W-1:0] r, input int k);
        t_div b;
        logic [DVD_W-1:0] d;
        b = a;
        d = DVD_W'(r) << k;
        if (a.rem >= d) begin
            b.rem  = a.rem - d;
            b.q[k] = 1'b1;
        end
        return b;
    endfunction

    // Signed normal from a finished division
    function automatic logic signed [NRM_W-1:0] div_result(input t_div d);
        logic signed [NRM_W-1:0] m;
        m = signed'({1'b0, d.q});
        return d.neg ? -m : m;
    endfunction

    // Start a division of |p| * 2^15 by the radius
    function automatic t_div div_init(input logic signed [P_W-1:0] p);
        t_div d;
        logic [P_W-1:0] mag;
        mag   = p[P_W-1] ? P_W'(-p) : P_W'(p);
        d.rem = DVD_W'(mag) << (DIV_STEPS - 1);
        d.q   = '0;
        d.neg = p[P_W-1];
        return d;
    endfunction

endpackage

>>> design/sts_ram.sv
module sts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port; read data holds without a read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> design/sphere_texture_shader_unit.sv
// Textured, lit sphere shader with an equirectangular texel memory.
// Input channel (i_s_*): tuser is the command, 0 writes a texel, 1 shades a pixel.
// A write stores tdata's texel at texel_index and gives no result. A shade
// gives one result on the output channel (o_m_*): tuser is covered, tdata the
// lit color, all zero when the pixel is off the sphere.
// Configuration channel (i_cfg_*): radius, longitude offset and ambient level,
// written only while the block is idle, a rule for the user that the block does
// not enforce; it is always ready.
// Throughput: one transaction per cycle unless a result is stalled. All stages
// move on one shared enable, and the texel memory's single read/write slot sits
// at one stage, so writes and reads keep their input order without forwarding.
// Depth comes from a 12-step square root, 20-step CORDIC units and 16-step
// dividers, one step per stage.
// Reset clears all valid flags and loads the configuration defaults; the
// texel memory is not cleared. When the receiver stalls a waiting result, the
// whole pipeline holds and o_s_tready drops in the same cycle.
`include "sphere_texture_shader_unit_defines.svh"

module sphere_texture_shader_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // texel_index, texel_red, texel_green, texel_blue, pixel_dx, pixel_dy, pad
    input  logic [sts_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // cmd
    input  logic                             i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // shade_red, shade_green, shade_blue
    output logic [sts_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    // covered
    output logic                             o_m_tuser,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sts_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sts_pkg::*;

    logic [RAD_W-1:0] r_rad;
    logic [LON_W-1:0] r_lon;
    logic [AMB_W-1:0] r_amb;

    logic             w_adv;
    logic [N_ST-1:0]  r_vld;
    t_side            r_side [N_ST];

    logic signed [OFS_W-1:0] r_dx, r_dy;
    logic signed [P_W-1:0]   r_px, r_py;
    logic [SQ_W-1:0]         r_px2, r_py2, r_r2;
    t_sq                     r_sq [SQ_STEPS+1];
    t_cord                   r_lonc [CORDIC_STEPS];
    t_cord                   r_latc [CORDIC_STEPS];
    t_div3                   r_div [DIV_STEPS];
    logic signed [SUM_W-1:0] r_s;
    logic [31:0]             r_dotp;
    logic [DOT_W-1:0]        r_dot;
    logic [LIGHT_W-1:0]      r_light [4];
    logic [LON_W-1:0]        r_u;
    logic [15:0]             r_v;
    logic [ADDR_W-1:0]       r_addr;
    logic [TEXEL_W-1:0]      r_orgb;

    logic                    w_ram_we, w_ram_re;
    logic [TEXEL_W-1:0]      w_ram_rdata;

    // Configuration writes
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad <= RADIUS_RST;
            r_lon <= '0;
            r_amb <= AMBIENT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_RADIUS:  r_rad <= i_cfg_data[RAD_W-1:0];
                REG_LON_OFS: r_lon <= i_cfg_data[LON_W-1:0];
                REG_AMBIENT: r_amb <= i_cfg_data[AMB_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the whole pipeline unless a result waits on a stalled receiver
    assign w_adv      = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_adv;

    // Stage 2 coverage test
    logic signed [SQ_W+1:0] w_disc, w_hd;
    logic                   w_cov;
    assign w_disc = $signed({2'b00, r_r2}) - $signed({2'b00, r_px2})
                  - $signed({2'b00, r_py2});
    assign w_hd   = $signed({2'b00, r_r2}) - $signed({2'b00, r_py2});
    assign w_cov  = (r_rad != '0) && !w_disc[SQ_W+1];

    // Valid flags and side data along all stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[N_ST-2:0], i_s_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0] <= '{cmd:   i_s_tuser,
                           widx:  i_s_tdata[12:0],
                           wdata: {i_s_tdata[20:13], i_s_tdata[28:21], i_s_tdata[36:29]},
                           cov:   1'b0};
            for (int k = 1; k < N_ST; k++) begin
                // Pick up the coverage flag on entry to the root stages
                if (k == ST_SQ0) begin
                    r_side[k] <= '{cmd:   r_side[k-1].cmd,
                                   widx:  r_side[k-1].widx,
                                   wdata: r_side[k-1].wdata,
                                   cov:   w_cov};
                end else begin
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    // Stages 0 and 1: capture offsets, then square them
    logic signed [P_W-1:0]     w_px, w_py;
    logic signed [2*P_W-1:0]   w_px_sq, w_py_sq;
    logic [2*RAD_W-1:0]        w_r_sq;
    assign w_px    = signed'({r_dx, 4'b0000});
    assign w_py    = signed'({r_dy, 4'b0000});
    assign w_px_sq = w_px * w_px;
    assign w_py_sq = w_py * w_py;
    assign w_r_sq  = r_rad * r_rad;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dx  <= signed'(i_s_tdata[45:37]);
            r_dy  <= signed'(i_s_tdata[54:46]);
            r_px  <= w_px;
            r_py  <= w_py;
            r_px2 <= w_px_sq[SQ_W-1:0];
            r_py2 <= w_py_sq[SQ_W-1:0];
            r_r2  <= SQ_W'(w_r_sq);
        end
    end

    // Two square roots, one result bit per stage
    for (genvar k = 0; k <= SQ_STEPS; k++) begin : g_sq
        if (k == 0) begin : g_init
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_sq[0].na <= w_cov ? w_disc[SQ_W-1:0] : '0;
                    r_sq[0].nb <= w_cov ? w_hd[SQ_W-1:0] : '0;
                    r_sq[0].ra <= '0;
                    r_sq[0].rb <= '0;
                    r_sq[0].px <= r_px;
                    r_sq[0].py <= r_py;
                end
            end
        end else begin : g_step
            localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - k));
            logic [SQ_W-1:0] w_ta, w_tb;
            assign w_ta = r_sq[k-1].ra + BIT;
            assign w_tb = r_sq[k-1].rb + BIT;
            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_sq[k].px <= r_sq[k-1].px;
                    r_sq[k].py <= r_sq[k-1].py;
                    if (r_sq[k-1].na >= w_ta) begin
                        r_sq[k].na <= r_sq[k-1].na - w_ta;
                        r_sq[k].ra <= (r_sq[k-1].ra >> 1) + BIT;
                    end else begin
                        r_sq[k].na <= r_sq[k-1].na;
                        r_sq[k].ra <= r_sq[k-1].ra >> 1;
                    end
                    if (r_sq[k-1].nb >= w_tb) begin
                        r_sq[k].nb <= r_sq[k-1].nb - w_tb;
                        r_sq[k].rb <= (r_sq[k-1].rb >> 1) + BIT;
                    end else begin
                        r_sq[k].nb <= r_sq[k-1].nb;
                        r_sq[k].rb <= r_sq[k-1].rb >> 1;
                    end
                end
            end
        end
    end

    // CORDIC and divider start values from the finished roots
    logic signed [P_W-1:0] w_spx, w_spy, w_pz, w_h, w_lat_x, w_lat_y;
    logic                  w_south;
    t_cord                 w_lon0, w_lat0;
    t_div3                 w_div0;
    assign w_spx   = r_sq[SQ_STEPS].px;
    assign w_spy   = r_sq[SQ_STEPS].py;
    assign w_pz    = signed'(r_sq[SQ_STEPS].ra[P_W-1:0]);
    assign w_h     = signed'(r_sq[SQ_STEPS].rb[P_W-1:0]);
    assign w_south = w_spy > 0;
    assign w_lat_x = w_south ? w_h : P_W'(-w_spy);
    assign w_lat_y = w_south ? w_spy : w_h;

    always_comb begin
        w_lon0.x       = CW'(w_pz) <<< 16;
        w_lon0.y       = CW'(w_spx) <<< 16;
        w_lon0.z       = '0;
        w_lon0.zero    = (w_pz == '0) && (w_spx == '0);
        w_lon0.quarter = 1'b0;
        w_lat0.x       = CW'(w_lat_x) <<< 16;
        w_lat0.y       = CW'(w_lat_y) <<< 16;
        w_lat0.z       = '0;
        w_lat0.zero    = (w_lat_x == '0) && (w_lat_y == '0);
        w_lat0.quarter = w_south;
        w_div0.x       = div_init(w_spx);
        w_div0.y       = div_init(w_spy);
        w_div0.z       = div_init(w_pz);
    end

    // Angle units: one rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cord
        t_cord w_lon_in, w_lat_in;
        if (i == 0) begin : g_first
            assign w_lon_in = w_lon0;
            assign w_lat_in = w_lat0;
        end else begin : g_next
            assign w_lon_in = r_lonc[i-1];
            assign w_lat_in = r_latc[i-1];
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_lonc[i] <= cord_step(w_lon_in, i);
                r_latc[i] <= cord_step(w_lat_in, i);
            end
        end
    end

    // Normal dividers: one quotient bit per stage, high bit first
    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
        t_div3 w_in;
        if (i == 0) begin : g_first
            assign w_in = w_div0;
        end else begin : g_next
            assign w_in = r_div[i-1];
        end
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_div[i].x <= div_step(w_in.x, r_rad, DIV_STEPS - 1 - i);
                r_div[i].y <= div_step(w_in.y, r_rad, DIV_STEPS - 1 - i);
                r_div[i].z <= div_step(w_in.z, r_rad, DIV_STEPS - 1 - i);
            end
        end
    end

    // Lambert term and ambient mix
    logic [AMB_W-1:0]    w_amb, w_amb_inv;
    logic [31:0]         w_dsh;
    assign w_amb     = (r_amb > AMB_FULL) ? AMB_FULL : r_amb;
    assign w_amb_inv = AMB_FULL - w_amb;
    assign w_dsh     = r_dotp >> 15;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s <= SUM_W'(div_result(r_div[DIV_STEPS-1].x))
                 + SUM_W'(div_result(r_div[DIV_STEPS-1].y))
                 + SUM_W'(div_result(r_div[DIV_STEPS-1].z));
            r_dotp <= (r_s > 0) ? 32'(r_s[NRM_W-1:0] * LIGHT_Q15) : '0;
            r_dot  <= (w_dsh > 32'(DOT_MAX)) ? DOT_MAX : w_dsh[DOT_W-1:0];
            r_light[0] <= LIGHT_W'({w_amb, 15'b0}) + LIGHT_W'(w_amb_inv * r_dot);
            for (int k = 1; k < 4; k++) begin
                r_light[k] <= r_light[k-1];
            end
        end
    end

    // Texture coordinates from the final angles
    t_cord                  w_lonf, w_latf;
    logic signed [ZW-1:0]   w_zl, w_zr, w_lat;
    logic signed [ZW+1:0]   w_vv;
    logic [ZW+1:0]          w_vsh;
    assign w_lonf = r_lonc[CORDIC_STEPS-1];
    assign w_latf = r_latc[CORDIC_STEPS-1];
    assign w_zl   = w_lonf.zero ? '0 : w_lonf.z;
    assign w_zr   = w_zl + ROUND_Q24;
    assign w_lat  = (w_latf.zero ? '0 : w_latf.z) + (w_latf.quarter ? QUARTER_Q24 : '0);
    assign w_vv   = $signed({w_lat[ZW-1], w_lat, 1'b0}) + (ZW+2)'(ROUND_Q24);
    assign w_vsh  = unsigned'(w_vv) >> ANG_SHIFT;

    // Texel address
    logic [31:0] w_colp, w_rowp;
    logic [COL_W-1:0] w_col;
    logic [ROW_W-1:0] w_row;
    assign w_colp = (32'(r_u) * 32'(TEX_WIDTH)) >> 16;
    assign w_rowp = (32'(r_v) * 32'(TEX_HEIGHT)) >> 16;
    assign w_col  = (w_colp > 32'(TEX_WIDTH - 1)) ? COL_W'(TEX_WIDTH - 1) : w_colp[COL_W-1:0];
    assign w_row  = (w_rowp > 32'(TEX_HEIGHT - 1)) ? ROW_W'(TEX_HEIGHT - 1) : w_rowp[ROW_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_u <= w_zr[ANG_SHIFT +: LON_W] + HALF_TURN_Q16 + r_lon;
            if (w_vv[ZW+1]) begin
                r_v <= '0;
            end else if (w_vsh > (ZW+2)'(V_MAX_Q16)) begin
                r_v <= V_MAX_Q16;
            end else begin
                r_v <= w_vsh[15:0];
            end
            r_addr <= ADDR_W'(32'(w_row) * 32'(TEX_WIDTH) + 32'(w_col));
        end
    end

    // Texel memory: writes and shade reads share one slot at the address stage
    assign w_ram_we = w_adv && r_vld[ST_ADDR] && (r_side[ST_ADDR].cmd == CMD_WRITE)
                    && (32'(r_side[ST_ADDR].widx) < 32'(TEX_SIZE));
    assign w_ram_re = w_adv && r_vld[ST_ADDR] && (r_side[ST_ADDR].cmd == CMD_SHADE)
                    && r_side[ST_ADDR].cov;

    sts_ram #(
        .WIDTH (TEXEL_W),
        .DEPTH (TEX_SIZE)
    ) u_tex_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (ADDR_W'(r_side[ST_ADDR].widx)),
        .i_wdata (r_side[ST_ADDR].wdata),
        .i_re    (w_ram_re),
        .i_raddr (r_addr),
        .o_rdata (w_ram_rdata)
    );

    // Scale each channel by the light level
    logic [TEXEL_W-1:0] w_lit;
    always_comb begin
        logic [31:0] prod;
        logic [31:0] v;
        w_lit = '0;
        for (int c = 0; c < 3; c++) begin
            prod = 32'(w_ram_rdata[c*CH_W +: CH_W]) * 32'(r_light[3]);
            v    = prod >> LIGHT_SHIFT;
            w_lit[(2-c)*CH_W +: CH_W] = (v > 32'd255) ? 8'hFF : v[CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_orgb <= r_side[ST_TEX].cov ? w_lit : '0;
        end
    end

    assign o_m_tvalid = r_vld[ST_OUT] && (r_side[ST_OUT].cmd == CMD_SHADE);
    assign o_m_tuser  = r_side[ST_OUT].cov;
    assign o_m_tdata  = r_orgb;

    `STS_ASSERT(a_uncov_zero, (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == '0), "uncovered pixel with color")
    `STS_ASSERT(a_ram_one_op, !(w_ram_we && w_ram_re), "texel read and write in one cycle")
    `STS_ASSERT(a_cov_radius, (o_m_tvalid && o_m_tuser) |-> (r_rad != '0), "covered with zero radius")
    `STS_ASSERT_NEXT(a_stall_hold, !w_adv && r_vld[ST_TEX] && r_side[ST_TEX].cov, $stable(r_vld[ST_TEX]) && $stable(w_ram_rdata), "texel lost in stall")

endmodule

>>> test/tb_sphere_texture_shader_unit.sv
`timescale 1ns / 100ps

module tb_sphere_texture_shader_unit;
    import sts_pkg::*;

    typedef struct packed {
        logic       cov;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_s_tvalid;
    logic                     o_s_tready;
    logic [IN_TDATA_W-1:0]    i_s_tdata;
    logic                     i_s_tuser;
    logic                     o_m_tvalid;
    logic                     i_m_tready;
    logic [OUT_TDATA_W-1:0]   o_m_tdata;
    logic                     o_m_tuser;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_DATA_W-1:0]    i_cfg_data;

    // Shadow of the texel memory and the registers
    logic [TEXEL_W-1:0]       texels [TEX_SIZE];
    bit                       tex_written [TEX_SIZE];
    logic [RAD_W-1:0]         radius_q4;
    logic [LON_W-1:0]         lon_offset;
    logic [AMB_W-1:0]         ambient;

    t_pixel                   pending_pixels[$];
    int                       mismatches;
    bit                       send_gaps;
    bit                       recv_stalls;
    int                       hold_off_cycles;

    sphere_texture_shader_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("tb_sphere_texture_shader_unit: FAIL");
        $finish;
    end

    // Right shift that rounds toward zero
    function automatic longint shr_zero(input longint v, input int s);
        if (v >= 0) begin
            return v >>> s;
        end
        return -((-v) >>> s);
    endfunction

    function automatic longint floor_sqrt(input longint v);
        longint root;
        longint trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Vectoring rotation: angle of (x, y) for x >= 0 in Q0.24 turns
    function automatic longint angle_q24(input longint x, input longint y);
        longint z;
        longint xs;
        longint ys;
        longint step [20] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
                              20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41,
                              20, 10, 5};
        z = 0;
        if (x == 0 && y == 0) begin
            return 0;
        end
        x = x * 65536;
        y = y * 65536;
        for (int i = 0; i < 20; i++) begin
            xs = shr_zero(x, i);
            ys = shr_zero(y, i);
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + step[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - step[i];
            end
        end
        return z;
    endfunction

    // Texel address of a pixel offset, or -1 when it misses the sphere
    function automatic int pixel_addr(input logic signed [8:0] dx,
                                      input logic signed [8:0] dy);
        longint r, px, py, pz, disc, h, lat, vv;
        logic [63:0] ang;
        logic [15:0] u;
        int col, row;
        r = radius_q4;
        px = longint'(dx) * 16;
        py = longint'(dy) * 16;
        disc = r * r - (px * px + py * py);
        if (r == 0 || disc < 0) begin
            return -1;
        end
        pz = floor_sqrt(disc);
        ang = angle_q24(pz, px) + 128;
        u = ang[23:8] + HALF_TURN_Q16 + lon_offset;
        col = int'(u >> 9);
        h = floor_sqrt(r * r - py * py);
        if (-py >= 0) begin
            lat = angle_q24(-py, h);
        end else begin
            lat = (longint'(1) << 22) + angle_q24(h, py);
        end
        vv = 2 * lat + 128;
        vv = (vv < 0) ? 0 : (vv >> 8);
        if (vv > V_MAX_Q16) vv = V_MAX_Q16;
        row = int'(vv >> 10);
        if (row > TEX_HEIGHT - 1) row = TEX_HEIGHT - 1;
        return row * TEX_WIDTH + col;
    endfunction

    // Lit texel color of one pixel offset on the sphere
    function automatic t_pixel shade_pixel(input logic signed [8:0] dx,
                                           input logic signed [8:0] dy);
        t_pixel res;
        longint r, px, py, pz, s, dot, amb, light, ch;
        int addr;
        logic [TEXEL_W-1:0] tx;
        res = '0;
        addr = pixel_addr(dx, dy);
        if (addr < 0) begin
            return res;
        end
        r = radius_q4;
        px = longint'(dx) * 16;
        py = longint'(dy) * 16;
        pz = floor_sqrt(r * r - (px * px + py * py));
        tx = texels[addr];
        s = (px * 32768) / r + (py * 32768) / r + (pz * 32768) / r;
        dot = (s <= 0) ? 0 : ((s * LIGHT_Q15) >> 15);
        if (dot > 32768) dot = 32768;
        amb = (ambient > AMB_FULL) ? 256 : ambient;
        light = amb * 32768 + (256 - amb) * dot;
        res.cov = 1'b1;
        ch = (tx[23:16] * light) >> 23;
        res.red = (ch > 255) ? 8'd255 : ch[7:0];
        ch = (tx[15:8] * light) >> 23;
        res.green = (ch > 255) ? 8'd255 : ch[7:0];
        ch = (tx[7:0] * light) >> 23;
        res.blue = (ch > 255) ? 8'd255 : ch[7:0];
        return res;
    endfunction

    // Offer one transaction; predict on acceptance
    task automatic send_item(input logic cmd, input logic [12:0] idx,
                             input logic [TEXEL_W-1:0] rgb,
                             input logic signed [8:0] dx, input logic signed [8:0] dy);
        int gap;
        gap = send_gaps ? $urandom_range(0, 10) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        i_s_tuser  <= cmd;
        i_s_tdata  <= {1'b0, dy, dx, rgb[7:0], rgb[15:8], rgb[23:16], idx};
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        if (cmd == CMD_WRITE) begin
            texels[idx] = rgb;
            tex_written[idx] = 1'b1;
        end else begin
            pending_pixels.push_back(shade_pixel(dx, dy));
        end
    endtask

    // Shade one pixel, writing its texel first if it was never written
    task automatic send_shade(input logic signed [8:0] dx, input logic signed [8:0] dy);
        int addr;
        addr = pixel_addr(dx, dy);
        if (addr >= 0 && !tex_written[addr]) begin
            send_item(CMD_WRITE, addr[12:0], 24'($urandom), 9'sd0, 9'sd0);
        end
        send_item(CMD_SHADE, 13'($urandom), 24'($urandom), dx, dy);
    endtask

    task automatic shade_random(input bit near);
        int lim;
        int dx;
        int dy;
        lim = (radius_q4 >> 4) + 2;
        if (near) begin
            dx = $urandom_range(0, 2 * lim) - lim;
            dy = $urandom_range(0, 2 * lim) - lim;
            if (dx > 255) dx = 255;
            if (dx < -256) dx = -256;
            if (dy > 255) dy = 255;
            if (dy < -256) dy = -256;
        end else begin
            dx = $urandom_range(0, 511) - 256;
            dy = $urandom_range(0, 511) - 256;
        end
        send_shade(9'(dx), 9'(dy));
    endtask

    task automatic mixed_items(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                send_item(CMD_WRITE, 13'($urandom), 24'($urandom), 9'($urandom),
                          9'($urandom));
            end else begin
                shade_random($urandom_range(0, 7) != 0);
            end
        end
    endtask

    // Drop valid, drain all results, then let trailing writes pass
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (45) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        wait_idle();
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_RADIUS:  radius_q4 = val[RAD_W-1:0];
            REG_LON_OFS: lon_offset = val;
            REG_AMBIENT: ambient = val[AMB_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_edge_offsets();
        send_gaps = 1'b1;
        send_shade(-9'sd256, -9'sd256);
        send_shade(9'sd255, 9'sd255);
        send_shade(9'sd0, 9'sd0);
        send_shade(9'sd0, -9'sd64);
        send_shade(9'sd0, 9'sd64);
        send_shade(-9'sd64, 9'sd0);
        send_shade(9'sd63, 9'sd0);
        send_shade(9'sd45, -9'sd45);
        send_item(CMD_WRITE, 13'h1FFF, 24'hFFFFFF, 9'sd0, 9'sd0);
        send_item(CMD_WRITE, 13'h0000, 24'hFFFFFF, 9'sd0, 9'sd0);
        send_shade(9'sd0, -9'sd63);
        send_shade(9'sd0, 9'sd63);
    endtask

    task automatic test_register_extremes();
        write_reg(REG_RADIUS, 16'd0);
        send_shade(9'sd0, 9'sd0);
        write_reg(REG_RADIUS, 16'hFFFF);
        write_reg(REG_LON_OFS, 16'hFFFF);
        write_reg(REG_AMBIENT, 16'h01FF);
        mixed_items(6);
        write_reg(REG_AMBIENT, 16'd0);
        write_reg(REG_LON_OFS, 16'h0000);
        mixed_items(6);
        write_reg(REG_AMBIENT, 16'd256);
        write_reg(REG_RADIUS, 16'd1);
        mixed_items(4);
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_RADIUS, 16'($urandom_range(16, 4095)));
            write_reg(REG_LON_OFS, 16'($urandom));
            write_reg(REG_AMBIENT, 16'($urandom_range(0, 511)));
            send_gaps   = (ph != 2);
            recv_stalls = (ph != 3);
            mixed_items(60);
        end
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
    endtask

    // Receiver holds off while the sender streams
    task automatic test_backpressure();
        send_gaps = 1'b0;
        hold_off_cycles = 300;
        mixed_items(100);
        send_gaps = 1'b1;
    endtask

    // Sender pauses until every result is in, then resumes
    task automatic test_drain_pause();
        mixed_items(40);
        wait_idle();
        mixed_items(40);
    endtask

    // Receiver: random stalls per result, plus requested hold-offs
    initial begin
        int n;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            n = recv_stalls ? $urandom_range(0, 10) : 0;
            if (hold_off_cycles > 0) begin
                n = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (n > 0) begin
                @(negedge i_clk);
                i_m_tready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_pixel exp_px;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected result cov=%0b rgb=%h", $time, o_m_tuser,
                         o_m_tdata);
                mismatches++;
            end else begin
                exp_px = pending_pixels.pop_front();
                if (o_m_tuser !== exp_px.cov) begin
                    $display("%0t: covered expected %0b actual %0b", $time, exp_px.cov,
                             o_m_tuser);
                    mismatches++;
                end
                if (o_m_tdata[7:0] !== exp_px.red) begin
                    $display("%0t: red expected %0d actual %0d", $time, exp_px.red,
                             o_m_tdata[7:0]);
                    mismatches++;
                end
                if (o_m_tdata[15:8] !== exp_px.green) begin
                    $display("%0t: green expected %0d actual %0d", $time, exp_px.green,
                             o_m_tdata[15:8]);
                    mismatches++;
                end
                if (o_m_tdata[23:16] !== exp_px.blue) begin
                    $display("%0t: blue expected %0d actual %0d", $time, exp_px.blue,
                             o_m_tdata[23:16]);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = CMD_WRITE;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_RADIUS;
        i_cfg_data  = '0;
        mismatches  = 0;
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        hold_off_cycles = 0;
        radius_q4   = RADIUS_RST;
        lon_offset  = '0;
        ambient     = AMBIENT_RST;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_edge_offsets();
        test_register_extremes();
        test_random_phases();
        test_backpressure();
        test_drain_pause();

        wait_idle();
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("tb_sphere_texture_shader_unit: PASS");
        end else begin
            $display("tb_sphere_texture_shader_unit: FAIL");
        end
        $finish;
    end

endmodule
